// ----- rtl/lmg_pkg.sv -----
// Shared types, codes and tables for the LED matrix glyph blit and scan block.
`default_nettype none

package lmg_pkg;

  // Command codes carried on the input item's tuser.
  typedef enum logic [2:0] {
    FUNC_FILL     = 3'd0,
    FUNC_BLIT_6X8 = 3'd1,
    FUNC_BLIT_5X8 = 3'd2,
    FUNC_BLIT_4X6 = 3'd3,
    FUNC_REFRESH  = 3'd4,
    FUNC_INIT     = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    CMD_FILL,
    CMD_BLIT,
    CMD_REFRESH,
    CMD_INIT
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLIT_RD,
    ST_BLIT_WR,
    ST_FRM_RD,
    ST_FRM_OUT
  } back_state_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] CFG_ENABLE     = 2'd1;
  localparam logic [1:0] CFG_MIRROR     = 2'd2;

  // Driver register addresses.
  localparam logic [3:0] REG_NOOP      = 4'h0;
  localparam logic [3:0] REG_DECODE    = 4'h9;
  localparam logic [3:0] REG_INTENSITY = 4'hA;
  localparam logic [3:0] REG_SCAN_LIM  = 4'hB;
  localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
  localparam logic [3:0] REG_TEST      = 4'hF;

  localparam int FB_ROWS = 8;
  localparam int ROW_AW  = 3;
  localparam int SLOTS   = 4;
  localparam int QDEPTH  = 2;

  // Frame sequence: setup frames, row frames, enable frame, brightness frame.
  localparam logic [4:0] FRM_ROW_FIRST = 5'd7;
  localparam logic [4:0] FRM_ENABLE    = 5'd15;
  localparam logic [4:0] FRM_BRIGHT    = 5'd16;

  localparam logic [3:0] BLIT6_W = 4'd6;
  localparam logic [3:0] BLIT5_W = 4'd5;
  localparam logic [3:0] BLIT4_W = 4'd4;
  localparam logic [3:0] BLIT6_H = 4'd8;
  localparam logic [3:0] BLIT5_H = 4'd8;
  localparam logic [3:0] BLIT4_H = 4'd6;
  localparam logic [7:0] BLIT6_MASK = 8'hfc;
  localparam logic [7:0] BLIT5_MASK = 8'hf8;
  localparam logic [7:0] BLIT4_MASK = 8'hf0;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [63:0]       glyph;
    logic [7:0]        fill;
    logic signed [4:0] xd;          // module index of the glyph's left edge
    logic [2:0]        xr;          // bit offset within that module
    logic [7:0]        mask;
    logic [2:0]        row_first;
    logic [2:0]        gidx_first;  // glyph row that lands on row_first
    logic [3:0]        row_cnt;
  } cmd_t;

  typedef struct packed {
    logic [3:0] bright;
    logic       enable;
    logic       mirror;
  } disp_cfg_t;

  function automatic logic [3:0] setup_reg(input logic [2:0] idx);
    case (idx)
      3'd0:    return REG_SHUTDOWN;
      3'd1:    return REG_NOOP;
      3'd2:    return REG_DECODE;
      3'd3:    return REG_TEST;
      3'd4:    return REG_SCAN_LIM;
      3'd5:    return REG_INTENSITY;
      3'd6:    return REG_SHUTDOWN;
      default: return REG_NOOP;
    endcase
  endfunction

  function automatic logic [7:0] setup_val(input logic [2:0] idx);
    case (idx)
      3'd0:    return 8'h00;
      3'd1:    return 8'hFF;
      3'd2:    return 8'h00;
      3'd3:    return 8'h00;
      3'd4:    return 8'h07;
      3'd5:    return 8'h04;
      3'd6:    return 8'h01;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = b[7-k];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lmg_front.sv -----
// Command classifier: decodes the input item, clips blits and builds a queue entry.
`default_nettype none

module lmg_front (
  input  wire logic [2:0]   func,
  input  wire logic [63:0]  glyph_rows,
  input  wire logic [7:0]   x_pos,
  input  wire logic [7:0]   y_pos,
  input  wire logic [7:0]   fill_byte,
  output lmg_pkg::cmd_t     cmd,
  output logic              keep
);

  logic [3:0]        width;
  logic [3:0]        rows;
  logic [7:0]        mask;
  logic signed [8:0] xs9;
  logic signed [8:0] ys9;
  logic signed [8:0] ylast9;
  logic signed [8:0] yneg9;
  logic              ok_x;
  logic              ok_y;
  logic              is_blit;
  logic [2:0]        row_first;
  logic [2:0]        row_last;

  always_comb begin
    width   = lmg_pkg::BLIT6_W;
    rows    = lmg_pkg::BLIT6_H;
    mask    = lmg_pkg::BLIT6_MASK;
    is_blit = 1'b0;
    keep    = 1'b0;
    cmd.kind = lmg_pkg::CMD_FILL;
    case (lmg_pkg::func_t'(func))
      lmg_pkg::FUNC_FILL: begin
        cmd.kind = lmg_pkg::CMD_FILL;
        keep     = 1'b1;
      end
      lmg_pkg::FUNC_BLIT_6X8: begin
        cmd.kind = lmg_pkg::CMD_BLIT;
        is_blit  = 1'b1;
      end
      lmg_pkg::FUNC_BLIT_5X8: begin
        cmd.kind = lmg_pkg::CMD_BLIT;
        is_blit  = 1'b1;
        width    = lmg_pkg::BLIT5_W;
        rows     = lmg_pkg::BLIT5_H;
        mask     = lmg_pkg::BLIT5_MASK;
      end
      lmg_pkg::FUNC_BLIT_4X6: begin
        cmd.kind = lmg_pkg::CMD_BLIT;
        is_blit  = 1'b1;
        width    = lmg_pkg::BLIT4_W;
        rows     = lmg_pkg::BLIT4_H;
        mask     = lmg_pkg::BLIT4_MASK;
      end
      lmg_pkg::FUNC_REFRESH: begin
        cmd.kind = lmg_pkg::CMD_REFRESH;
        keep     = 1'b1;
      end
      lmg_pkg::FUNC_INIT: begin
        cmd.kind = lmg_pkg::CMD_INIT;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase

    xs9    = {x_pos[7], x_pos};
    ys9    = {y_pos[7], y_pos};
    ylast9 = ys9 + $signed({5'b0, rows}) - 9'sd1;
    yneg9  = 9'sd0 - ys9;
    ok_x   = (xs9 + $signed({5'b0, width})) >= 9'sd1;
    ok_y   = (ylast9 >= 9'sd0) && (ys9 <= 9'sd7);

    row_first = ys9[8] ? 3'd0 : ys9[2:0];
    row_last  = (ylast9 > 9'sd7) ? 3'd7 : ylast9[2:0];

    // A blit that lands entirely above, below or left of the buffer leaves no trace, so it is dropped here.
    if (is_blit) begin
      keep = ok_x && ok_y;
    end

    cmd.glyph      = glyph_rows;
    cmd.fill       = fill_byte;
    cmd.xd         = $signed(x_pos[7:3]);
    cmd.xr         = x_pos[2:0];
    cmd.mask       = mask;
    cmd.row_first  = row_first;
    cmd.gidx_first = ys9[8] ? yneg9[2:0] : 3'd0;
    cmd.row_cnt    = {1'b0, row_last} - {1'b0, row_first} + 4'd1;
  end

endmodule

`default_nettype wire

// ----- rtl/lmg_cmd_fifo.sv -----
// Short command queue between the classifier and the executor.
`default_nettype none

module lmg_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  lmg_pkg::cmd_t      push_cmd,
  output logic               full,
  input  wire logic          pop,
  output lmg_pkg::cmd_t      head_cmd,
  output logic               empty
);

  localparam int PTR_W = (lmg_pkg::QDEPTH > 1) ? $clog2(lmg_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(lmg_pkg::QDEPTH + 1);

  lmg_pkg::cmd_t    entry_r [lmg_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(lmg_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(lmg_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(lmg_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lmg_back.sv -----
// Command executor: framebuffer row memory, blit read-modify-write and frame scan-out.
`default_nettype none

module lmg_back #(
  parameter int NUM_MODULES = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  lmg_pkg::disp_cfg_t  dcfg,
  input  wire logic           q_empty,
  input  lmg_pkg::cmd_t       q_cmd,
  output logic                q_pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [39:0]         out_tdata,
  output logic                out_tlast
);

  localparam int FB_W = NUM_MODULES * 8;

  lmg_pkg::back_state_t state_r, state_nxt;
  lmg_pkg::cmd_t        cmd_r, cmd_nxt;

  logic [lmg_pkg::ROW_AW-1:0] row_r, row_nxt;
  logic [2:0]                 gidx_r, gidx_nxt;
  logic [3:0]                 cnt_r, cnt_nxt;
  logic [4:0]                 fidx_r, fidx_nxt;
  logic [7:0]                 bg_r, bg_nxt;
  logic [lmg_pkg::FB_ROWS-1:0] rvalid_r, rvalid_nxt;

  // Framebuffer: one memory row holds one display row across all modules.
  logic [FB_W-1:0]            fb_mem [lmg_pkg::FB_ROWS];
  logic [FB_W-1:0]            rd_data_r;
  logic                       rd_vld_r;
  logic                       mem_re;
  logic                       mem_we;
  logic [lmg_pkg::ROW_AW-1:0] raddr;
  logic [FB_W-1:0]            row_eff;
  logic [FB_W-1:0]            blit_data;

  logic                       out_valid_r;
  logic [3:0]                 out_reg_r;
  logic [31:0]                out_data_r;
  logic                       out_last_r;
  logic                       out_load;
  logic [3:0]                 frm_reg;
  logic [31:0]                frm_data;
  logic [lmg_pkg::ROW_AW-1:0] frm_row;
  logic                       frm_is_row;
  logic                       out_free;

  function automatic logic [31:0] broadcast(input logic [7:0] v);
    logic [31:0] d;
    d = '0;
    for (int j = 0; j < lmg_pkg::SLOTS; j++) begin
      if (j < NUM_MODULES) begin
        d[(lmg_pkg::SLOTS-1-j)*8 +: 8] = v;
      end
    end
    return d;
  endfunction

  function automatic logic [31:0] row_frame(input logic [FB_W-1:0] row, input logic mirror);
    logic [31:0] d;
    int          m;
    d = '0;
    for (int j = 0; j < lmg_pkg::SLOTS; j++) begin
      if (j < NUM_MODULES) begin
        if (mirror) begin
          m = j;
          d[(lmg_pkg::SLOTS-1-j)*8 +: 8] = lmg_pkg::rev8(row[m*8 +: 8]);
        end else begin
          m = NUM_MODULES - 1 - j;
          d[(lmg_pkg::SLOTS-1-j)*8 +: 8] = row[m*8 +: 8];
        end
      end
    end
    return d;
  endfunction

  function automatic logic [FB_W-1:0] blit_row(input logic [FB_W-1:0] row,
                                               input logic [7:0] g,
                                               input logic [7:0] mask,
                                               input logic signed [4:0] xd,
                                               input logic [2:0] xr);
    logic [15:0]       wg;
    logic [15:0]       wm;
    logic [FB_W-1:0]   r;
    logic signed [5:0] xd6;
    logic signed [5:0] m6;
    wg  = {g, 8'h00} >> xr;
    wm  = {mask, 8'h00} >> xr;
    r   = row;
    xd6 = {xd[4], xd};
    for (int m = 0; m < NUM_MODULES; m++) begin
      m6 = $signed(6'(m));
      if (m6 == xd6) begin
        r[m*8 +: 8] = (r[m*8 +: 8] & ~wm[15:8]) | wg[15:8];
      end
      if (m6 == xd6 + 6'sd1) begin
        r[m*8 +: 8] = (r[m*8 +: 8] & ~wm[7:0]) | wg[7:0];
      end
    end
    return r;
  endfunction

  // A row never written since the last fill or clear reads as the background byte.
  assign row_eff   = rd_vld_r ? rd_data_r : {NUM_MODULES{bg_r}};
  assign blit_data = blit_row(row_eff, cmd_r.glyph[{~gidx_r, 3'b000} +: 8], cmd_r.mask,
                              cmd_r.xd, cmd_r.xr);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    frm_row    = 3'(fidx_r - lmg_pkg::FRM_ROW_FIRST);
    frm_is_row = (fidx_r >= lmg_pkg::FRM_ROW_FIRST) && (fidx_r < lmg_pkg::FRM_ENABLE);
    if (fidx_r < lmg_pkg::FRM_ROW_FIRST) begin
      frm_reg  = lmg_pkg::setup_reg(fidx_r[2:0]);
      frm_data = broadcast(lmg_pkg::setup_val(fidx_r[2:0]));
    end else if (frm_is_row) begin
      frm_reg  = 4'(frm_row) + 4'd1;
      frm_data = row_frame(row_eff, dcfg.mirror);
    end else if (fidx_r == lmg_pkg::FRM_ENABLE) begin
      frm_reg  = lmg_pkg::REG_SHUTDOWN;
      frm_data = broadcast({7'd0, dcfg.enable});
    end else begin
      frm_reg  = lmg_pkg::REG_INTENSITY;
      frm_data = broadcast({4'd0, dcfg.bright});
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    row_nxt    = row_r;
    gidx_nxt   = gidx_r;
    cnt_nxt    = cnt_r;
    fidx_nxt   = fidx_r;
    bg_nxt     = bg_r;
    rvalid_nxt = rvalid_r;
    q_pop      = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    raddr      = row_r;
    out_load   = 1'b0;
    case (state_r)
      lmg_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          case (q_cmd.kind)
            lmg_pkg::CMD_FILL: begin
              bg_nxt     = q_cmd.fill;
              rvalid_nxt = '0;
            end
            lmg_pkg::CMD_BLIT: begin
              row_nxt   = q_cmd.row_first;
              gidx_nxt  = q_cmd.gidx_first;
              cnt_nxt   = q_cmd.row_cnt;
              state_nxt = lmg_pkg::ST_BLIT_RD;
            end
            lmg_pkg::CMD_REFRESH: begin
              fidx_nxt  = lmg_pkg::FRM_ROW_FIRST;
              state_nxt = lmg_pkg::ST_FRM_RD;
            end
            lmg_pkg::CMD_INIT: begin
              bg_nxt     = 8'h00;
              rvalid_nxt = '0;
              fidx_nxt   = '0;
              state_nxt  = lmg_pkg::ST_FRM_RD;
            end
            default: begin
              state_nxt = lmg_pkg::ST_IDLE;
            end
          endcase
        end
      end
      lmg_pkg::ST_BLIT_RD: begin
        mem_re    = 1'b1;
        state_nxt = lmg_pkg::ST_BLIT_WR;
      end
      lmg_pkg::ST_BLIT_WR: begin
        mem_we          = 1'b1;
        rvalid_nxt[row_r] = 1'b1;
        if (cnt_r == 4'd1) begin
          state_nxt = lmg_pkg::ST_IDLE;
        end else begin
          row_nxt   = row_r + 1'b1;
          gidx_nxt  = gidx_r + 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = lmg_pkg::ST_BLIT_RD;
        end
      end
      lmg_pkg::ST_FRM_RD: begin
        mem_re    = frm_is_row;
        raddr     = dcfg.mirror ? ~frm_row : frm_row;
        state_nxt = lmg_pkg::ST_FRM_OUT;
      end
      lmg_pkg::ST_FRM_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (fidx_r == lmg_pkg::FRM_BRIGHT) begin
            state_nxt = lmg_pkg::ST_IDLE;
          end else begin
            fidx_nxt  = fidx_r + 1'b1;
            state_nxt = lmg_pkg::ST_FRM_RD;
          end
        end
      end
      default: begin
        state_nxt = lmg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lmg_pkg::ST_IDLE;
      bg_r        <= 8'h00;
      rvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bg_r     <= bg_nxt;
      rvalid_r <= rvalid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    row_r  <= row_nxt;
    gidx_r <= gidx_nxt;
    cnt_r  <= cnt_nxt;
    fidx_r <= fidx_nxt;
    if (out_load) begin
      out_reg_r  <= frm_reg;
      out_data_r <= frm_data;
      out_last_r <= (fidx_r == lmg_pkg::FRM_BRIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fb_mem[row_r] <= blit_data;
    end
    if (mem_re) begin
      rd_data_r <= fb_mem[raddr];
      rd_vld_r  <= rvalid_r[raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r, out_reg_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/led_matrix_glyph_blit_and_scan.sv -----
// LED matrix framebuffer with glyph blit and frame scan-out: top level.
// Items enter a 2-entry command queue, one per cycle while it has room; the idle executor pops
// each: a fill sets the background byte, a blit reads and writes back each touched row in turn,
// refresh sends the row, enable and brightness frames, and init sends the setup frames first.
// Each frame takes a row memory read, then an output load, and waits while the sink stalls.
// Reset (synchronous, active low) empties the queue and marks every framebuffer row unwritten,
// so the buffer reads as zeros at once; configuration returns to brightness 1, enabled, unmirrored.
`default_nettype none

module led_matrix_glyph_blit_and_scan #(
  parameter int NUM_MODULES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // glyph_rows[63:0], x_pos[71:64], y_pos[79:72], fill_byte[87:80]
  input  wire logic [2:0]  in_tuser,   // func[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // reg_addr[3:0], frame_data[35:4], zero pad[39:36]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);

  logic [4:0]         bright_lvl_r;
  logic               enable_r;
  logic               mirror_r;
  lmg_pkg::disp_cfg_t dcfg;
  lmg_pkg::cmd_t      front_cmd;
  logic               front_keep;
  lmg_pkg::cmd_t      head_cmd;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_lvl_r <= 5'd1;
      enable_r     <= 1'b1;
      mirror_r     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lmg_pkg::CFG_BRIGHTNESS: bright_lvl_r <= cfg_data;
        lmg_pkg::CFG_ENABLE:     enable_r     <= cfg_data[0];
        lmg_pkg::CFG_MIRROR:     mirror_r     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Level zero wraps below zero and levels above sixteen clamp; both send full intensity.
  always_comb begin
    dcfg.bright = (bright_lvl_r == 5'd0 || bright_lvl_r > 5'd16) ? 4'hF
                                                                  : 4'(bright_lvl_r - 5'd1);
    dcfg.enable = enable_r;
    dcfg.mirror = mirror_r;
  end

  assign in_tready = !q_full;

  lmg_front u_front (
    .func       (in_tuser),
    .glyph_rows (in_tdata[63:0]),
    .x_pos      (in_tdata[71:64]),
    .y_pos      (in_tdata[79:72]),
    .fill_byte  (in_tdata[87:80]),
    .cmd        (front_cmd),
    .keep       (front_keep)
  );

  lmg_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_tvalid && front_keep),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  lmg_back #(
    .NUM_MODULES (NUM_MODULES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dcfg       (dcfg),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/lmg_checker.sv -----
// Port-level assertions for the LED matrix block and the bind that attaches them.
`default_nettype none

module lmg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast
);

  // A frame held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // The closing frame of every refresh or init is the brightness frame.
  a_last_is_bright: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[3:0] == lmg_pkg::REG_INTENSITY)
    else $error("final frame is not a brightness frame");

  // Frames that address a row carry no last marker.
  a_row_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] != lmg_pkg::REG_NOOP && out_tdata[3:0] < lmg_pkg::REG_DECODE
    |-> !out_tlast)
    else $error("row frame marked last");

  // Reset leaves no stale frame on the output.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:36] == 4'h0)
    else $error("pad bits of output item not zero");

endmodule

bind led_matrix_glyph_blit_and_scan lmg_checker u_lmg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
